/* rtl/core/sm3he_pkg.sv */
`timescale 1ns / 1ps
// sm3he_pkg: shared types, constants and helper functions of the sm3 hash engine
// used by sm3he_ctrl, sm3he_datapath and sm3_hash_engine; no dependencies

package sm3he_pkg;

  localparam logic [31:0] T_LOW  = 32'h79CC4519;
  localparam logic [31:0] T_HIGH = 32'h7A879D8A;
  localparam logic [7:0]  PAD_BYTE = 8'h80;
  localparam logic [2:0]  MAX_BYTES = 3'd4;
  localparam logic [5:0]  LAST_ROUND = 6'd63;
  localparam logic [2:0]  LAST_WORD_IDX = 3'd7;

  typedef enum logic [1:0] {
    SRC_DATA = 2'd0,
    SRC_PAD  = 2'd1,
    SRC_ZERO = 2'd2,
    SRC_LEN  = 2'd3
  } byte_src_t;

  typedef struct packed {
    logic      load_item;
    logic      push;
    byte_src_t src;
    logic [2:0] sel;
    logic      cmp_init;
    logic      round;
    logic [5:0] round_j;
    logic      cmp_fin;
    logic      out_load;
    logic [2:0] out_idx;
    logic      msg_clear;
  } dp_cmd_t;

  typedef struct packed {
    logic fill_wrap;   // next push completes a block
    logic fill_at55;   // next push leaves 56 bytes in the block
  } dp_status_t;

  function automatic logic [31:0] iv_word(input logic [2:0] i);
    logic [31:0] v;
    unique case (i)
      3'd0: v = 32'h7380166F;
      3'd1: v = 32'h4914B2B9;
      3'd2: v = 32'h172442D7;
      3'd3: v = 32'hDA8A0600;
      3'd4: v = 32'hA96F30BC;
      3'd5: v = 32'h163138AA;
      3'd6: v = 32'hE38DEE4D;
      default: v = 32'hB0FB0E4E;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] t;
    t = {x, x} << n;
    return t[63:32];
  endfunction

  function automatic logic [31:0] p0(input logic [31:0] x);
    return x ^ {x[22:0], x[31:23]} ^ {x[14:0], x[31:15]};
  endfunction

  function automatic logic [31:0] p1(input logic [31:0] x);
    return x ^ {x[16:0], x[31:17]} ^ {x[8:0], x[31:9]};
  endfunction

endpackage

/* rtl/core/sm3he_datapath.sv */
`timescale 1ns / 1ps
// sm3he_datapath: byte packer, message window, round logic, chain value and digest register
// depends on sm3he_pkg

module sm3he_datapath (
  input  logic                  clk,
  input  logic                  rst,
  input  sm3he_pkg::dp_cmd_t    cmd,
  output sm3he_pkg::dp_status_t status,
  input  logic [31:0]           data_word,
  output logic [31:0]           digest_word,
  output logic [2:0]            word_index,
  output logic                  digest_last
);

  logic [31:0] chain [8];
  logic [31:0] wv [8];
  logic [31:0] win [16];
  logic [31:0] item_word;
  logic [31:0] partial;
  logic [5:0]  fill;
  logic [60:0] msg_bytes;

  logic [7:0]  push_byte;
  logic [63:0] bit_len;
  logic [31:0] partial_next;
  logic [31:0] tj, a12, ss1, ss2, ff, gg, tt1, tt2, w_new;
  logic        early;

  assign status.fill_wrap = (fill == 6'd63);
  assign status.fill_at55 = (fill == 6'd55);
  assign bit_len = {msg_bytes, 3'b000};

  always_comb begin
    unique case (cmd.src)
      sm3he_pkg::SRC_DATA: push_byte = item_word[8'(31 - 8 * cmd.sel[1:0]) -: 8];
      sm3he_pkg::SRC_PAD:  push_byte = sm3he_pkg::PAD_BYTE;
      sm3he_pkg::SRC_ZERO: push_byte = 8'h00;
      default:             push_byte = bit_len[8'(63 - 8 * cmd.sel) -: 8];
    endcase
    unique case (fill[1:0])
      2'd0: partial_next = {push_byte, partial[23:0]};
      2'd1: partial_next = {partial[31:24], push_byte, partial[15:0]};
      2'd2: partial_next = {partial[31:16], push_byte, partial[7:0]};
      default: partial_next = {partial[31:8], push_byte};
    endcase
  end

  // one compression round
  always_comb begin
    early = (cmd.round_j < 6'd16);
    tj    = early ? sm3he_pkg::T_LOW : sm3he_pkg::T_HIGH;
    a12   = {wv[0][19:0], wv[0][31:20]};
    ss1   = a12 + wv[4] + sm3he_pkg::rotl(tj, cmd.round_j[4:0]);
    ss1   = {ss1[24:0], ss1[31:25]};
    ss2   = ss1 ^ a12;
    ff    = early ? (wv[0] ^ wv[1] ^ wv[2])
                  : ((wv[0] & wv[1]) | (wv[0] & wv[2]) | (wv[1] & wv[2]));
    gg    = early ? (wv[4] ^ wv[5] ^ wv[6]) : ((wv[4] & wv[5]) | (~wv[4] & wv[6]));
    tt1   = ff + wv[3] + ss2 + (win[0] ^ win[4]);
    tt2   = gg + wv[7] + ss1 + win[0];
    w_new = sm3he_pkg::p1(win[0] ^ win[7] ^ {win[13][16:0], win[13][31:17]})
          ^ {win[3][24:0], win[3][31:25]} ^ win[10];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      partial   <= '0;
      fill      <= '0;
      msg_bytes <= '0;
      for (int i = 0; i < 8; i++) chain[i] <= sm3he_pkg::iv_word(3'(i));
    end else begin
      if (cmd.push) begin
        if (fill[1:0] == 2'd3) begin
          win[fill[5:2]] <= partial_next;
          partial <= '0;
        end else begin
          partial <= partial_next;
        end
        fill <= fill + 6'd1;
        if (cmd.src == sm3he_pkg::SRC_DATA) msg_bytes <= msg_bytes + 61'd1;
      end
      if (cmd.cmp_fin) begin
        for (int i = 0; i < 8; i++) chain[i] <= chain[i] ^ wv[i];
      end
      if (cmd.msg_clear) begin
        partial   <= '0;
        fill      <= '0;
        msg_bytes <= '0;
        for (int i = 0; i < 8; i++) chain[i] <= sm3he_pkg::iv_word(3'(i));
      end
    end
    if (cmd.load_item) item_word <= data_word;
    if (cmd.cmp_init) begin
      for (int i = 0; i < 8; i++) wv[i] <= chain[i];
    end
    if (cmd.round) begin
      wv[0] <= tt1;
      wv[1] <= wv[0];
      wv[2] <= {wv[1][22:0], wv[1][31:23]};
      wv[3] <= wv[2];
      wv[4] <= sm3he_pkg::p0(tt2);
      wv[5] <= wv[4];
      wv[6] <= {wv[5][12:0], wv[5][31:13]};
      wv[7] <= wv[6];
      for (int i = 0; i < 15; i++) win[i] <= win[i + 1];
      win[15] <= w_new;
    end
    if (cmd.out_load) begin
      digest_word <= chain[cmd.out_idx];
      word_index  <= cmd.out_idx;
      digest_last <= (cmd.out_idx == sm3he_pkg::LAST_WORD_IDX);
    end
  end

endmodule

/* rtl/core/sm3he_ctrl.sv */
`timescale 1ns / 1ps
// sm3he_ctrl: sequencer for byte packing, padding, compression rounds and digest output
// depends on sm3he_pkg

module sm3he_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  data_valid,
  output logic                  data_stall,
  input  logic [2:0]            byte_count,
  input  logic                  last_word,
  output logic                  digest_valid,
  input  logic                  digest_stall,
  output sm3he_pkg::dp_cmd_t    cmd,
  input  sm3he_pkg::dp_status_t status
);

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_PUSH  = 9'b000000010,
    ST_PAD80 = 9'b000000100,
    ST_ZERO  = 9'b000001000,
    ST_LEN   = 9'b000010000,
    ST_CINIT = 9'b000100000,
    ST_ROUND = 9'b001000000,
    ST_CFIN  = 9'b010000000,
    ST_OUT   = 9'b100000000
  } state_t;

  state_t     state, state_next, ret, ret_next, after;
  logic [2:0] k, k_next, oidx, oidx_next, item_cnt, cnt_sat;
  logic [5:0] rnd, rnd_next;
  logic       item_last, slot_free, accept;

  assign data_stall = (state != ST_IDLE);
  assign accept     = data_valid && !data_stall;
  assign cnt_sat    = (byte_count > sm3he_pkg::MAX_BYTES) ? sm3he_pkg::MAX_BYTES : byte_count;
  assign slot_free  = !digest_valid || !digest_stall;

  always_comb begin
    cmd        = '0;
    cmd.src    = sm3he_pkg::SRC_DATA;
    cmd.sel    = k;
    cmd.round_j = rnd;
    cmd.out_idx = oidx;
    state_next = state;
    ret_next   = ret;
    k_next     = k;
    rnd_next   = rnd;
    oidx_next  = oidx;
    after      = ST_IDLE;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          cmd.load_item = 1'b1;
          k_next = '0;
          if (cnt_sat != 3'd0) state_next = ST_PUSH;
          else if (last_word) state_next = ST_PAD80;
        end
      end
      ST_PUSH: begin
        cmd.push = 1'b1;
        k_next = k + 3'd1;
        if (k + 3'd1 == item_cnt) after = item_last ? ST_PAD80 : ST_IDLE;
        else after = ST_PUSH;
      end
      ST_PAD80, ST_ZERO: begin
        cmd.push = 1'b1;
        cmd.src  = (state == ST_PAD80) ? sm3he_pkg::SRC_PAD : sm3he_pkg::SRC_ZERO;
        k_next   = '0;
        after    = status.fill_at55 ? ST_LEN : ST_ZERO;
      end
      ST_LEN: begin
        cmd.push = 1'b1;
        cmd.src  = sm3he_pkg::SRC_LEN;
        k_next   = k + 3'd1;
        after    = (k == 3'd7) ? ST_OUT : ST_LEN;
      end
      ST_CINIT: begin
        cmd.cmp_init = 1'b1;
        rnd_next = '0;
        state_next = ST_ROUND;
      end
      ST_ROUND: begin
        cmd.round = 1'b1;
        rnd_next = rnd + 6'd1;
        if (rnd == sm3he_pkg::LAST_ROUND) state_next = ST_CFIN;
      end
      ST_CFIN: begin
        cmd.cmp_fin = 1'b1;
        state_next = ret;
      end
      default: begin
        if (slot_free) begin
          cmd.out_load = 1'b1;
          oidx_next = oidx + 3'd1;
          if (oidx == sm3he_pkg::LAST_WORD_IDX) begin
            cmd.msg_clear = 1'b1;
            state_next = ST_IDLE;
          end
        end
      end
    endcase
    if (cmd.push) begin
      ret_next   = after;
      state_next = status.fill_wrap ? ST_CINIT : after;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      ret          <= ST_IDLE;
      k            <= '0;
      rnd          <= '0;
      oidx         <= '0;
      item_cnt     <= '0;
      item_last    <= 1'b0;
      digest_valid <= 1'b0;
    end else begin
      state <= state_next;
      ret   <= ret_next;
      k     <= k_next;
      rnd   <= rnd_next;
      oidx  <= oidx_next;
      if (accept) begin
        item_cnt  <= cnt_sat;
        item_last <= last_word;
      end
      digest_valid <= cmd.out_load || (digest_valid && digest_stall);
    end
  end

  a_round_end: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ROUND && rnd == sm3he_pkg::LAST_ROUND) |=> state == ST_CFIN)
    else $error("round counter did not end compression");
  a_ret_sane: assert property (@(posedge clk) disable iff (rst)
    state == ST_CFIN |-> (ret != ST_CFIN && ret != ST_ROUND && ret != ST_CINIT))
    else $error("bad return state after compression");
  a_wrap_cmp: assert property (@(posedge clk) disable iff (rst)
    (cmd.push && status.fill_wrap) |=> state == ST_CINIT)
    else $error("full block not compressed");
  a_out_end: assert property (@(posedge clk) disable iff (rst)
    (cmd.out_load && oidx == sm3he_pkg::LAST_WORD_IDX) |=> state == ST_IDLE)
    else $error("digest output did not finish");

endmodule

/* rtl/core/sm3_hash_engine.sv */
`timescale 1ns / 1ps
// sm3_hash_engine: top level of the streaming sm3 digest engine
// depends on sm3he_pkg, sm3he_ctrl and sm3he_datapath

// The engine takes a message as big-endian 32-bit words (byte_count valid bytes from the
// top, last_word on the final transaction) and returns the eight digest words, one per
// output transaction, then restarts from the initial value. Bytes are packed one per
// cycle while no block is being compressed; every completed 64-byte block is compressed
// by a load, 64 rounds through one shared round unit and a chain update. After the final
// transaction the padding is packed the same way, one byte per cycle (9 to 72 bytes, more
// than 64 only when a second block is needed), followed by one or two compressions and
// eight output transactions. The input is stalled from the accept until that work is
// done, and no new word is taken until the bytes of the current one are packed.

module sm3_hash_engine (
  input  logic        clk,
  input  logic        rst,
  input  logic        data_valid,
  output logic        data_stall,
  input  logic [31:0] data_word,
  input  logic [2:0]  byte_count,
  input  logic        last_word,
  output logic        digest_valid,
  input  logic        digest_stall,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        digest_last
);

  // command and status between sequencer and datapath
  sm3he_pkg::dp_cmd_t    cmd;
  sm3he_pkg::dp_status_t status;

  sm3he_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .data_valid   (data_valid),
    .data_stall   (data_stall),
    .byte_count   (byte_count),
    .last_word    (last_word),
    .digest_valid (digest_valid),
    .digest_stall (digest_stall),
    .cmd          (cmd),
    .status       (status)
  );

  sm3he_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .data_word   (data_word),
    .digest_word (digest_word),
    .word_index  (word_index),
    .digest_last (digest_last)
  );

endmodule

/* sim/sm3_hash_engine_tb.sv */
`timescale 1ns / 1ps
// sm3_hash_engine_tb: self-checking testbench of the streaming sm3 digest engine
// depends on sm3he_pkg and the sm3_hash_engine rtl; carries its own sm3 digest predictor

typedef struct packed {
  logic [31:0] word;
  logic [2:0]  idx;
  logic        last;
} digest_item_t;

class digest_board;
  // running message state of the predictor
  logic [31:0] chain[8];
  logic [31:0] blk[16];
  logic [31:0] part;
  logic [5:0]  fill;
  logic [60:0] msg_len;
  digest_item_t pending_digests[$];
  int errors;

  function new();
    errors = 0;
    restart();
  endfunction

  function void restart();
    chain[0] = 32'h7380166F; chain[1] = 32'h4914B2B9;
    chain[2] = 32'h172442D7; chain[3] = 32'hDA8A0600;
    chain[4] = 32'hA96F30BC; chain[5] = 32'h163138AA;
    chain[6] = 32'hE38DEE4D; chain[7] = 32'hB0FB0E4E;
    part = '0;
    fill = '0;
    msg_len = '0;
  endfunction

  function logic [31:0] rol(logic [31:0] x, int n);
    n = n % 32;
    if (n == 0) return x;
    return (x << n) | (x >> (32 - n));
  endfunction

  function void compress();
    logic [31:0] w[68];
    logic [31:0] v[8];
    logic [31:0] a12, ss1, ss2, ff, gg, tt1, tt2, tj;
    for (int j = 0; j < 16; j++) w[j] = blk[j];
    for (int j = 16; j < 68; j++) begin
      tt1 = w[j-16] ^ w[j-9] ^ rol(w[j-3], 15);
      w[j] = tt1 ^ rol(tt1, 15) ^ rol(tt1, 23) ^ rol(w[j-13], 7) ^ w[j-6];
    end
    for (int j = 0; j < 8; j++) v[j] = chain[j];
    for (int r = 0; r < 64; r++) begin
      tj = (r < 16) ? sm3he_pkg::T_LOW : sm3he_pkg::T_HIGH;
      a12 = rol(v[0], 12);
      ss1 = rol(a12 + v[4] + rol(tj, r), 7);
      ss2 = ss1 ^ a12;
      ff = (r < 16) ? (v[0] ^ v[1] ^ v[2]) : ((v[0] & v[1]) | (v[0] & v[2]) | (v[1] & v[2]));
      gg = (r < 16) ? (v[4] ^ v[5] ^ v[6]) : ((v[4] & v[5]) | (~v[4] & v[6]));
      tt1 = ff + v[3] + ss2 + (w[r] ^ w[r+4]);
      tt2 = gg + v[7] + ss1 + w[r];
      v[3] = v[2]; v[2] = rol(v[1], 9); v[1] = v[0]; v[0] = tt1;
      v[7] = v[6]; v[6] = rol(v[5], 19); v[5] = v[4];
      v[4] = tt2 ^ rol(tt2, 9) ^ rol(tt2, 17);
    end
    for (int j = 0; j < 8; j++) chain[j] ^= v[j];
  endfunction

  function void push_byte(logic [7:0] b);
    part |= 32'(b) << (8 * (3 - fill[1:0]));
    if (fill[1:0] == 2'd3) begin
      blk[fill[5:2]] = part;
      part = '0;
    end
    fill = fill + 6'd1;
    if (fill == 0) compress();
  endfunction

  // note an accepted input transaction; queues eight digest words on the last one
  function void note_word(logic [31:0] data, logic [2:0] cnt, logic last);
    logic [63:0] bits;
    digest_item_t d;
    int n;
    n = (cnt > 4) ? 4 : cnt;
    for (int i = 0; i < n; i++) begin
      push_byte(data[31 - 8*i -: 8]);
      msg_len = msg_len + 61'd1;
    end
    if (!last) return;
    bits = {msg_len, 3'b000};
    push_byte(sm3he_pkg::PAD_BYTE);
    while (fill != 6'd56) push_byte(8'h00);
    for (int i = 0; i < 8; i++) push_byte(bits[63 - 8*i -: 8]);
    for (int i = 0; i < 8; i++) begin
      d.word = chain[i];
      d.idx = 3'(i);
      d.last = (i == 7);
      pending_digests.push_back(d);
    end
    restart();
  endfunction

  function void check_digest(logic [31:0] word, logic [2:0] idx, logic last);
    digest_item_t e;
    if (pending_digests.size() == 0) begin
      $display("%0t: unexpected digest transaction word %h idx %0d", $time, word, idx);
      errors++;
      return;
    end
    e = pending_digests.pop_front();
    if (word !== e.word || idx !== e.idx || last !== e.last) begin
      $display("%0t: digest mismatch expected %h/%0d/%0d actual %h/%0d/%0d",
               $time, e.word, e.idx, e.last, word, idx, last);
      errors++;
    end
  endfunction
endclass

module sm3_hash_engine_tb;
  localparam int IDLE_LIMIT = 20000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        data_valid = 1'b0;
  logic        data_stall;
  logic [31:0] data_word = '0;
  logic [2:0]  byte_count = '0;
  logic        last_word = 1'b0;
  logic        digest_valid;
  logic        digest_stall = 1'b0;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        digest_last;

  // idle and stall rates in percent for the current phase
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int idle_cycles = 0;
  digest_board board;

  sm3_hash_engine u_dut (
    .clk(clk), .rst(rst),
    .data_valid(data_valid), .data_stall(data_stall),
    .data_word(data_word), .byte_count(byte_count), .last_word(last_word),
    .digest_valid(digest_valid), .digest_stall(digest_stall),
    .digest_word(digest_word), .word_index(word_index), .digest_last(digest_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver side: check at the rising edge, pick the next stall at the falling edge
  always @(posedge clk) begin
    if (!rst && digest_valid && !digest_stall)
      board.check_digest(digest_word, word_index, digest_last);
  end

  always @(negedge clk) begin
    digest_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if ((data_valid && !data_stall) || (digest_valid && !digest_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("sm3_hash_engine test failed");
      $finish;
    end
  end

  // drive one input transaction, holding it until accepted; valid drops only when idling
  task automatic send_word(input logic [31:0] data, input logic [2:0] cnt, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      data_valid <= 1'b0;
      @(negedge clk);
    end
    data_valid <= 1'b1;
    data_word <= data;
    byte_count <= cnt;
    last_word <= last;
    @(posedge clk);
    while (data_stall) @(posedge clk);
    board.note_word(data, cnt, last);
    @(negedge clk);
  endtask

  // random message of nwords words (mostly full) and a final word of 0 to 4 bytes; byte_count may exceed four
  task automatic send_message(input int nwords);
    logic [2:0] cnt;
    for (int i = 0; i < nwords; i++) begin
      cnt = ($urandom_range(19) == 0) ? 3'($urandom_range(7)) : 3'd4;
      send_word($urandom, cnt, 1'b0);
    end
    send_word($urandom, 3'($urandom_range(7)), 1'b1);
  endtask

  task automatic drain();
    data_valid <= 1'b0;
    while (board.pending_digests.size() != 0) @(negedge clk);
  endtask

  initial begin
    board = new();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: empty message, field extremes, padding boundary at 55 bytes
    send_word(32'h0, 3'd0, 1'b1);
    send_word(32'h61626300, 3'd3, 1'b1);
    send_word(32'hFFFFFFFF, 3'd4, 1'b1);
    send_word(32'hFFFFFFFF, 3'd7, 1'b0);
    send_word(32'h00000000, 3'd5, 1'b1);
    send_word(32'h12345678, 3'd1, 1'b0);
    send_word(32'h9ABCDEF0, 3'd2, 1'b1);
    for (int i = 0; i < 13; i++) send_word(32'hA5A5A5A5 ^ i, 3'd4, 1'b0);
    send_word(32'h5A5A5A5A, 3'd3, 1'b1);
    drain();

    // random phases: none, sender idle, receiver stall, both
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1) ? 80 : (ph == 3) ? 28 : 0;
      recv_stall_pct = (ph == 2) ? 80 : (ph == 3) ? 28 : 0;
      for (int m = 0; m < 9; m++) begin
        send_message((m == 4) ? 31 : $urandom_range(13));
        // after the third message the sender holds off until every digest word is out
        if (m == 2) drain();
      end
    end

    drain();
    repeat (300) @(posedge clk);
    if (board.errors == 0 && board.pending_digests.size() == 0)
      $display("sm3_hash_engine test passed");
    else
      $display("sm3_hash_engine test failed");
    $finish;
  end
endmodule

/* sm3_hash_engine.f */
rtl/core/sm3he_pkg.sv
rtl/core/sm3he_datapath.sv
rtl/core/sm3he_ctrl.sv
rtl/core/sm3_hash_engine.sv
sim/sm3_hash_engine_tb.sv
